// ===== rtl/core/nfc_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nfc_pkg
// Shared types and codes of the nor flash command controller: command modes,
// bus status codes, unlock addresses and command bytes.
// ----------------------------------------------------------------------------
package nfc_pkg;

   localparam int MEM_BYTES_DEF    = 131072;
   localparam int SECTOR_BYTES_DEF = 16384;
   localparam int SECTOR_SHIFT_DEF = 16;

   localparam int ADDR_BITS = 24;
   localparam int DATA_BITS = 8;

   localparam logic CMD_READ  = 1'b0;
   localparam logic CMD_WRITE = 1'b1;

   localparam logic [1:0] ST_OK          = 2'd0;
   localparam logic [1:0] ST_UNMAPPED    = 2'd1;
   localparam logic [1:0] ST_UNPERMITTED = 2'd2;
   localparam logic [1:0] ST_REFUSED     = 2'd3;

   localparam logic [ADDR_BITS-1:0] UNLOCK_ADDR1 = 24'h000555;
   localparam logic [ADDR_BITS-1:0] UNLOCK_ADDR2 = 24'h0002AA;

   localparam logic [DATA_BITS-1:0] CODE_UNLOCK1    = 8'hAA;
   localparam logic [DATA_BITS-1:0] CODE_UNLOCK2    = 8'h55;
   localparam logic [DATA_BITS-1:0] CODE_AUTOSELECT = 8'h90;
   localparam logic [DATA_BITS-1:0] CODE_ERASE      = 8'h80;
   localparam logic [DATA_BITS-1:0] CODE_CHIP_ERASE = 8'h10;
   localparam logic [DATA_BITS-1:0] CODE_SECT_ERASE = 8'h30;
   localparam logic [DATA_BITS-1:0] CODE_PROGRAM    = 8'hA0;
   localparam logic [DATA_BITS-1:0] CODE_BYPASS     = 8'h20;
   localparam logic [DATA_BITS-1:0] CODE_EXIT       = 8'hF0;
   localparam logic [DATA_BITS-1:0] ERASED_BYTE     = 8'hFF;

   localparam logic [3:0] AUTOSEL_MANUFACTURER = 4'h0;
   localparam logic [3:0] AUTOSEL_DEVICE       = 4'h1;

   localparam logic REG_DEVICE_ID       = 1'b0;
   localparam logic REG_MANUFACTURER_ID = 1'b1;

   typedef enum logic [9:0] {
      MODE_READ         = 10'b0000000001,
      MODE_UNLOCK1      = 10'b0000000010,
      MODE_UNLOCK2      = 10'b0000000100,
      MODE_AUTOSELECT   = 10'b0000001000,
      MODE_PROGRAM      = 10'b0000010000,
      MODE_ERASE0       = 10'b0000100000,
      MODE_ERASE1       = 10'b0001000000,
      MODE_ERASE2       = 10'b0010000000,
      MODE_BYPASS       = 10'b0100000000,
      MODE_BYPASS_RESET = 10'b1000000000
   } mode_type;

   typedef struct packed {
      mode_type             next_mode;
      logic [1:0]           status;
      logic [DATA_BITS-1:0] read_data;
      logic                 do_program;
      logic                 chip_erase;
      logic                 sector_erase;
   } dec_type;

endpackage

// ===== rtl/core/nfc_cmd_decode.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nfc_cmd_decode
// Command mode decoder: from the current mode and one bus beat it works out
// the next mode, the status, the read byte and the array action to take.
// ----------------------------------------------------------------------------
module nfc_cmd_decode
   import nfc_pkg::*;
(
   input  logic                 command,
   input  mode_type             mode,
   input  logic [ADDR_BITS-1:0] address,
   input  logic [DATA_BITS-1:0] write_data,
   input  logic                 in_range,
   input  logic [DATA_BITS-1:0] mem_data,
   input  logic [DATA_BITS-1:0] device_id,
   input  logic [DATA_BITS-1:0] manufacturer_id,
   output dec_type              dec
);

   logic at_addr1;
   logic at_addr2;

   assign at_addr1 = (address == UNLOCK_ADDR1);
   assign at_addr2 = (address == UNLOCK_ADDR2);

   always_comb begin
      dec              = '0;
      dec.next_mode    = mode;
      dec.status       = ST_OK;
      dec.read_data    = '0;
      dec.do_program   = 1'b0;
      dec.chip_erase   = 1'b0;
      dec.sector_erase = 1'b0;
      if (command == CMD_READ) begin
         if (mode == MODE_AUTOSELECT) begin
            if (address[3:0] == AUTOSEL_MANUFACTURER) begin
               dec.read_data = manufacturer_id;
            end else if (address[3:0] == AUTOSEL_DEVICE) begin
               dec.read_data = device_id;
            end
         end else if (!in_range) begin
            dec.status = ST_UNMAPPED;
         end else begin
            dec.read_data = mem_data;
         end
      end else begin
         unique case (mode)
            MODE_READ: begin
               if (at_addr1 && write_data == CODE_UNLOCK1) begin
                  dec.next_mode = MODE_UNLOCK1;
               end else begin
                  dec.status = ST_UNPERMITTED;
               end
            end
            MODE_AUTOSELECT: begin
               if (write_data == CODE_EXIT) begin
                  dec.next_mode = MODE_READ;
               end
            end
            MODE_BYPASS: begin
               if (write_data == CODE_PROGRAM) begin
                  dec.next_mode = MODE_PROGRAM;
               end else if (write_data == CODE_AUTOSELECT) begin
                  dec.next_mode = MODE_BYPASS_RESET;
               end else begin
                  dec.next_mode = MODE_READ;
               end
            end
            MODE_BYPASS_RESET: begin
               dec.next_mode = MODE_READ;
            end
            MODE_ERASE0: begin
               dec.next_mode = (at_addr1 && write_data == CODE_UNLOCK1) ?
                               MODE_ERASE1 : MODE_READ;
            end
            MODE_ERASE1: begin
               dec.next_mode = (at_addr2 && write_data == CODE_UNLOCK2) ?
                               MODE_ERASE2 : MODE_READ;
            end
            MODE_ERASE2: begin
               dec.next_mode = MODE_READ;
               if (at_addr1 && write_data == CODE_CHIP_ERASE) begin
                  dec.chip_erase = 1'b1;
               end else if (write_data == CODE_SECT_ERASE) begin
                  dec.sector_erase = 1'b1;
               end
            end
            MODE_UNLOCK1: begin
               dec.next_mode = (at_addr2 && write_data == CODE_UNLOCK2) ?
                               MODE_UNLOCK2 : MODE_READ;
            end
            MODE_UNLOCK2: begin
               if (at_addr1 && write_data == CODE_AUTOSELECT) begin
                  dec.next_mode = MODE_AUTOSELECT;
               end else if (at_addr1 && write_data == CODE_PROGRAM) begin
                  dec.next_mode = MODE_PROGRAM;
               end else if (at_addr1 && write_data == CODE_ERASE) begin
                  dec.next_mode = MODE_ERASE0;
               end else if (at_addr1 && write_data == CODE_BYPASS) begin
                  dec.next_mode = MODE_BYPASS;
               end else begin
                  dec.next_mode = MODE_READ;
               end
            end
            MODE_PROGRAM: begin
               if (!in_range) begin
                  dec.status = ST_UNMAPPED;
               end else begin
                  dec.do_program = 1'b1;
                  dec.next_mode  = MODE_READ;
               end
            end
            default: begin
               dec.status = ST_REFUSED;
            end
         endcase
      end
   end

endmodule

// ===== rtl/core/nor_flash_command_controller.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nor_flash_command_controller
// Byte-wide nor flash model with unlock command sequences, autoselect,
// program, unlock bypass, chip erase and sector erase.
// ----------------------------------------------------------------------------
// usage:
//   req_* carries one bus beat (read or write, address, data); rsp_* returns
//   one beat per request with the read byte and a status code.
//   reads and plain writes are served through the single-port array: the
//   addressed byte is read in the accept cycle, then decoded and written back
//   in the next. a new request is taken only after the last one is decoded.
//   chip erase walks the whole array, one byte a cycle.
//   sector erase walks at most one sector of the array.
//   after reset the same sweep clears the array to 0xff; req_ready stays
//   low meanwhile, config writes are taken.
//   the result sits in an output register; if rsp_ready is low the next
//   request is still decoded, and it waits only for the register to drain.
//   device_id and manufacturer_id sit on the apb port at 0x0 and 0x4.
// ----------------------------------------------------------------------------
module nor_flash_command_controller
   import nfc_pkg::*;
#(
   parameter int MEM_BYTES    = MEM_BYTES_DEF,
   parameter int SECTOR_BYTES = SECTOR_BYTES_DEF,
   parameter int SECTOR_SHIFT = SECTOR_SHIFT_DEF
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  logic                 req_command,
   input  logic [ADDR_BITS-1:0] req_address,
   input  logic [DATA_BITS-1:0] req_write_data,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output logic [DATA_BITS-1:0] rsp_read_data,
   output logic [1:0]           rsp_status,
   input  logic                 psel,
   input  logic                 penable,
   input  logic                 pwrite,
   input  logic [2:0]           paddr,
   input  logic [31:0]          pwdata,
   output logic [31:0]          prdata,
   output logic                 pready
);

   localparam int IDX_W  = $clog2(MEM_BYTES);
   localparam int CNT_W  = IDX_W + 1;
   localparam int SIDX_W = ADDR_BITS - SECTOR_SHIFT;
   localparam int SB_W   = $clog2(SECTOR_BYTES + 1);
   localparam int PROD_W = SIDX_W + SB_W;
   localparam int WIDE_W = ((PROD_W > CNT_W) ? PROD_W : CNT_W) + 1;

   typedef enum logic [5:0] {
      S_CLEAR = 6'b000001,
      S_IDLE  = 6'b000010,
      S_EXEC  = 6'b000100,
      S_SETUP = 6'b001000,
      S_ERASE = 6'b010000,
      S_POST  = 6'b100000
   } seq_type;

   seq_type              state_ff, state_in;
   mode_type             mode_ff, mode_in;
   logic                 cmd_ff, cmd_in;
   logic [ADDR_BITS-1:0] addr_ff, addr_in;
   logic [DATA_BITS-1:0] data_ff, data_in;
   logic [CNT_W-1:0]     wp_ff, wp_in;
   logic [CNT_W-1:0]     end_ff, end_in;
   logic [WIDE_W-1:0]    start_ff, start_in;
   logic [DATA_BITS-1:0] res_rd_ff, res_rd_in;
   logic [1:0]           res_st_ff, res_st_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [DATA_BITS-1:0] rsp_rd_ff, rsp_rd_in;
   logic [1:0]           rsp_st_ff, rsp_st_in;
   logic [DATA_BITS-1:0] dev_id_ff, dev_id_in;
   logic [DATA_BITS-1:0] man_id_ff, man_id_in;

   logic [DATA_BITS-1:0] mem [MEM_BYTES];
   logic [DATA_BITS-1:0] mem_q;
   logic                 mem_we;
   logic [IDX_W-1:0]     mem_addr;
   logic [DATA_BITS-1:0] mem_wdata;

   dec_type              dec;
   logic                 in_range;
   logic                 slot_free;
   logic                 rsp_load;
   logic [CNT_W-1:0]     wp_next;
   logic [WIDE_W-1:0]    sect_end;
   logic                 csr_wr;

   // configuration port
   assign pready = 1'b1;
   assign csr_wr = psel && penable && pwrite;

   always_comb begin
      dev_id_in = dev_id_ff;
      man_id_in = man_id_ff;
      if (csr_wr) begin
         if (paddr[2] == REG_DEVICE_ID) begin
            dev_id_in = pwdata[DATA_BITS-1:0];
         end else begin
            man_id_in = pwdata[DATA_BITS-1:0];
         end
      end
   end

   assign prdata = (paddr[2] == REG_DEVICE_ID) ? {24'd0, dev_id_ff} : {24'd0, man_id_ff};

   // flash array, one port
   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_addr] <= mem_wdata;
      end else begin
         mem_q <= mem[mem_addr];
      end
   end

   assign in_range = (addr_ff < ADDR_BITS'(MEM_BYTES));

   nfc_cmd_decode u_decode (
      .command         (cmd_ff),
      .mode            (mode_ff),
      .address         (addr_ff),
      .write_data      (data_ff),
      .in_range        (in_range),
      .mem_data        (mem_q),
      .device_id       (dev_id_ff),
      .manufacturer_id (man_id_ff),
      .dec             (dec)
   );

   assign slot_free = !rsp_valid_ff || rsp_ready;
   assign wp_next   = wp_ff + CNT_W'(1);
   assign sect_end  = start_ff + WIDE_W'(SECTOR_BYTES);

   always_comb begin
      state_in  = state_ff;
      mode_in   = mode_ff;
      cmd_in    = cmd_ff;
      addr_in   = addr_ff;
      data_in   = data_ff;
      wp_in     = wp_ff;
      end_in    = end_ff;
      start_in  = start_ff;
      res_rd_in = res_rd_ff;
      res_st_in = res_st_ff;
      rsp_load  = 1'b0;
      rsp_rd_in = res_rd_ff;
      rsp_st_in = res_st_ff;
      req_ready = 1'b0;
      mem_we    = 1'b0;
      mem_addr  = wp_ff[IDX_W-1:0];
      mem_wdata = ERASED_BYTE;
      unique case (state_ff)
         S_CLEAR, S_ERASE: begin
            mem_we = 1'b1;
            wp_in  = wp_next;
            if (wp_next == end_ff) begin
               state_in = (state_ff == S_CLEAR) ? S_IDLE : S_POST;
            end
         end
         S_IDLE: begin
            req_ready = 1'b1;
            mem_addr  = req_address[IDX_W-1:0];
            if (req_valid) begin
               cmd_in   = req_command;
               addr_in  = req_address;
               data_in  = req_write_data;
               state_in = S_EXEC;
            end
         end
         S_EXEC: begin
            mode_in   = dec.next_mode;
            res_rd_in = dec.read_data;
            res_st_in = dec.status;
            rsp_rd_in = dec.read_data;
            rsp_st_in = dec.status;
            mem_addr  = addr_ff[IDX_W-1:0];
            mem_wdata = mem_q & data_ff;
            mem_we    = dec.do_program;
            if (dec.chip_erase) begin
               wp_in    = '0;
               end_in   = CNT_W'(MEM_BYTES);
               state_in = S_ERASE;
            end else if (dec.sector_erase) begin
               start_in = WIDE_W'(addr_ff[ADDR_BITS-1:SECTOR_SHIFT]) *
                          WIDE_W'(SECTOR_BYTES);
               state_in = S_SETUP;
            end else if (slot_free) begin
               rsp_load = 1'b1;
               state_in = S_IDLE;
            end else begin
               state_in = S_POST;
            end
         end
         S_SETUP: begin
            if (start_ff < WIDE_W'(MEM_BYTES)) begin
               wp_in    = CNT_W'(start_ff);
               end_in   = (sect_end > WIDE_W'(MEM_BYTES)) ? CNT_W'(MEM_BYTES) :
                          CNT_W'(sect_end);
               state_in = S_ERASE;
            end else begin
               state_in = S_POST;
            end
         end
         S_POST: begin
            if (slot_free) begin
               rsp_load = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         mode_ff      <= MODE_READ;
         wp_ff        <= '0;
         end_ff       <= CNT_W'(MEM_BYTES);
         rsp_valid_ff <= 1'b0;
         dev_id_ff    <= 8'h20;
         man_id_ff    <= 8'h01;
      end else begin
         state_ff     <= state_in;
         mode_ff      <= mode_in;
         wp_ff        <= wp_in;
         end_ff       <= end_in;
         rsp_valid_ff <= rsp_valid_in;
         dev_id_ff    <= dev_id_in;
         man_id_ff    <= man_id_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff    <= cmd_in;
      addr_ff   <= addr_in;
      data_ff   <= data_in;
      start_ff  <= start_in;
      res_rd_ff <= res_rd_in;
      res_st_ff <= res_st_in;
      if (rsp_load) begin
         rsp_rd_ff <= rsp_rd_in;
         rsp_st_ff <= rsp_st_in;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_read_data = rsp_rd_ff;
   assign rsp_status    = rsp_st_ff;

   a_clear_no_rsp : assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_CLEAR) |-> !rsp_valid_ff)
      else $error("response pending during clearing sweep");

   a_accept_exec : assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> (state_ff == S_EXEC))
      else $error("accepted beat not decoded next cycle");

   a_sweep_bound : assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_ERASE || state_ff == S_CLEAR) |-> (wp_ff < end_ff))
      else $error("erase pointer beyond range end");

   a_mode_hold : assert property (@(posedge clock) disable iff (reset)
      (state_ff != S_EXEC) |=> $stable(mode_ff))
      else $error("command mode changed outside decode");

endmodule
